FILE: design/tpsc_pkg.sv
// Package for the two-point sensor calibration block.
// Holds the beat and configuration types, register codes, divider sizing and the divider step.
// Depends on nothing; every other design file uses it by scoped names.
`default_nettype none

package tpsc_pkg;

    localparam int HUM_FULL_SCALE   = 1000;
    localparam int TEMP_MAX         = 32767;
    localparam int TEMP_MIN         = -32768;

    localparam int DIV_W            = 28;
    localparam int DIV_STEPS        = 4;
    localparam int DIV_STAGES       = DIV_W / DIV_STEPS;

    localparam int ADDR_W           = 5;
    localparam int DATA_W           = 32;

    typedef enum logic [2:0] {
        REG_HUM_P0_PCT  = 3'd0,
        REG_HUM_P1_PCT  = 3'd1,
        REG_HUM_P0_CNT  = 3'd2,
        REG_HUM_P1_CNT  = 3'd3,
        REG_TEMP_P0_DEG = 3'd4,
        REG_TEMP_P1_DEG = 3'd5,
        REG_TEMP_P0_CNT = 3'd6,
        REG_TEMP_P1_CNT = 3'd7
    } reg_index_t;

    typedef enum logic {
        FUNC_HUM  = 1'b0,
        FUNC_TEMP = 1'b1
    } func_t;

    typedef struct packed {
        logic        [6:0]  hum_point0_percent;
        logic        [6:0]  hum_point1_percent;
        logic signed [15:0] hum_point0_count;
        logic signed [15:0] hum_point1_count;
        logic        [6:0]  temp_point0_degrees;
        logic        [6:0]  temp_point1_degrees;
        logic signed [15:0] temp_point0_count;
        logic signed [15:0] temp_point1_count;
    } cal_cfg_t;

    typedef struct packed {
        logic               func;
        logic signed [15:0] raw_sample;
    } sample_beat_t;

    typedef struct packed {
        logic signed [15:0] reading_tenths;
        logic               cal_error;
    } reading_beat_t;

    // One divider stage: sideband plus partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic              func;
        logic              err;
        logic              sign;
        logic [10:0]       unit0_tenths;
        logic [15:0]       den;
        logic [15:0]       rem;
        logic [DIV_W-1:0]  num;
    } div_stage_t;

    typedef struct packed {
        logic [15:0]       rem;
        logic [DIV_W-1:0]  num;
    } div_rn_t;

    // One restoring step: shift in the next dividend bit, subtract when it fits
    function automatic div_rn_t div_step(div_rn_t cur, logic [15:0] den);
        logic [16:0] trial;
        div_rn_t     nxt;
        trial = {cur.rem, cur.num[DIV_W-1]};
        if (trial >= {1'b0, den})
        begin
            nxt.rem = 16'(trial - {1'b0, den});
            nxt.num = {cur.num[DIV_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = trial[15:0];
            nxt.num = {cur.num[DIV_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

FILE: design/tpsc_front.sv
// Front end of the calibration pipeline: point select, differences, product, magnitudes.
// Three register stages; uses tpsc_pkg types.
`default_nettype none

module tpsc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tpsc_pkg::cal_cfg_t    cfg,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire tpsc_pkg::sample_beat_t in_beat,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output tpsc_pkg::div_stage_t       out_data
);

    typedef struct packed {
        logic               func;
        logic               err;
        logic signed [16:0] diff;
        logic signed [11:0] du10;
        logic signed [16:0] den;
        logic        [10:0] unit0_tenths;
    } s1_t;

    typedef struct packed {
        logic               func;
        logic               err;
        logic signed [28:0] prod;
        logic signed [16:0] den;
        logic        [10:0] unit0_tenths;
    } s2_t;

    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    tpsc_pkg::div_stage_t s3_reg, s3_next;

    assign ready3   = !v3_reg || !out_stall;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;

    // Stage 1: pick the channel's points, form differences
    always_comb
    begin
        logic        [6:0]  u0, u1;
        logic signed [15:0] c0, c1;
        logic        [7:0]  du;
        logic signed [11:0] du_x;
        if (in_beat.func == tpsc_pkg::FUNC_TEMP)
        begin
            u0 = cfg.temp_point0_degrees;
            u1 = cfg.temp_point1_degrees;
            c0 = cfg.temp_point0_count;
            c1 = cfg.temp_point1_count;
        end
        else
        begin
            u0 = cfg.hum_point0_percent;
            u1 = cfg.hum_point1_percent;
            c0 = cfg.hum_point0_count;
            c1 = cfg.hum_point1_count;
        end
        du   = {1'b0, u1} - {1'b0, u0};
        du_x = {{4{du[7]}}, du};
        s1_next.func         = in_beat.func;
        s1_next.err          = (c1 == c0);
        s1_next.diff         = {in_beat.raw_sample[15], in_beat.raw_sample} - {c0[15], c0};
        s1_next.den          = {c1[15], c1} - {c0[15], c0};
        s1_next.du10         = (du_x <<< 3) + (du_x <<< 1);
        s1_next.unit0_tenths = {1'b0, u0, 3'b000} + {3'b000, u0, 1'b0};
    end

    // Stage 2: the one multiply
    always_comb
    begin
        logic signed [28:0] a, b;
        a = {{12{s1_reg.diff[16]}}, s1_reg.diff};
        b = {{17{s1_reg.du10[11]}}, s1_reg.du10};
        s2_next.func         = s1_reg.func;
        s2_next.err          = s1_reg.err;
        s2_next.prod         = 29'(a * b);
        s2_next.den          = s1_reg.den;
        s2_next.unit0_tenths = s1_reg.unit0_tenths;
    end

    // Stage 3: magnitudes and result sign for the unsigned divider
    always_comb
    begin
        logic [28:0] pneg;
        logic [16:0] dneg;
        pneg = -s2_reg.prod;
        dneg = -s2_reg.den;
        s3_next.func         = s2_reg.func;
        s3_next.err          = s2_reg.err;
        s3_next.sign         = s2_reg.prod[28] ^ s2_reg.den[16];
        s3_next.unit0_tenths = s2_reg.unit0_tenths;
        s3_next.num          = s2_reg.prod[28] ? pneg[27:0] : s2_reg.prod[27:0];
        s3_next.den          = s2_reg.den[16] ? dneg[15:0] : s2_reg.den[15:0];
        s3_next.rem          = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1) v1_reg <= in_valid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1) s1_reg <= s1_next;
        if (ready2) s2_reg <= s2_next;
        if (ready3) s3_reg <= s3_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

endmodule

`default_nettype wire

FILE: design/tpsc_div.sv
// Pipelined restoring divider of the calibration block, a few quotient bits per stage.
// Carries the sideband of each beat alongside; uses tpsc_pkg types and div_step.
`default_nettype none

module tpsc_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire tpsc_pkg::div_stage_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output tpsc_pkg::div_stage_t       out_data
);

    localparam int N = tpsc_pkg::DIV_STAGES;

    logic                 v_reg  [N];
    logic                 src_v  [N];
    tpsc_pkg::div_stage_t st_reg [N];
    tpsc_pkg::div_stage_t src    [N];
    tpsc_pkg::div_stage_t st_next[N];
    logic [N:0]           ready;

    always_comb
    begin
        ready[N] = !out_stall;
        for (int i = N - 1; i >= 0; i--)
        begin
            ready[i] = !v_reg[i] || ready[i+1];
        end
    end

    assign in_stall = !ready[0];

    always_comb
    begin
        src[0]   = in_data;
        src_v[0] = in_valid;
        for (int i = 1; i < N; i++)
        begin
            src[i]   = st_reg[i-1];
            src_v[i] = v_reg[i-1];
        end
    end

    // Advance each stage's remainder by its share of quotient bits
    always_comb
    begin
        tpsc_pkg::div_rn_t rn;
        for (int i = 0; i < N; i++)
        begin
            rn.rem = src[i].rem;
            rn.num = src[i].num;
            for (int k = 0; k < tpsc_pkg::DIV_STEPS; k++)
            begin
                rn = tpsc_pkg::div_step(rn, src[i].den);
            end
            st_next[i]     = src[i];
            st_next[i].rem = rn.rem;
            st_next[i].num = rn.num;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (ready[i]) v_reg[i] <= src_v[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (ready[i]) st_reg[i] <= st_next[i];
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_data  = st_reg[N-1];

endmodule

`default_nettype wire

FILE: design/tpsc_back.sv
// Back end of the calibration pipeline: quotient sign, offset add, saturation, output register.
// Two register stages; uses tpsc_pkg types and limits.
`default_nettype none

module tpsc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire tpsc_pkg::div_stage_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output tpsc_pkg::reading_beat_t    out_beat
);

    typedef struct packed {
        logic               func;
        logic               err;
        logic signed [28:0] quot;
        logic        [10:0] unit0_tenths;
    } b1_t;

    logic v1_reg, v2_reg;
    logic ready1, ready2;
    b1_t  b1_reg, b1_next;
    tpsc_pkg::reading_beat_t b2_reg, b2_next;

    assign ready2   = !v2_reg || !out_stall;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;

    // Restore the quotient's sign
    always_comb
    begin
        logic [28:0] q;
        q = {1'b0, in_data.num};
        b1_next.func         = in_data.func;
        b1_next.err          = in_data.err;
        b1_next.quot         = in_data.sign ? -q : q;
        b1_next.unit0_tenths = in_data.unit0_tenths;
    end

    // Add the offset of point zero and clamp to the channel's range
    always_comb
    begin
        logic signed [29:0] r;
        r = {b1_reg.quot[28], b1_reg.quot} + {19'b0, b1_reg.unit0_tenths};
        if (b1_reg.err)
        begin
            b2_next.reading_tenths = '0;
        end
        else if (b1_reg.func == tpsc_pkg::FUNC_HUM)
        begin
            if (r < 30'sd0)
                b2_next.reading_tenths = '0;
            else if (r > 30'(tpsc_pkg::HUM_FULL_SCALE))
                b2_next.reading_tenths = 16'(tpsc_pkg::HUM_FULL_SCALE);
            else
                b2_next.reading_tenths = r[15:0];
        end
        else
        begin
            if (r < 30'(tpsc_pkg::TEMP_MIN))
                b2_next.reading_tenths = 16'(tpsc_pkg::TEMP_MIN);
            else if (r > 30'(tpsc_pkg::TEMP_MAX))
                b2_next.reading_tenths = 16'(tpsc_pkg::TEMP_MAX);
            else
                b2_next.reading_tenths = r[15:0];
        end
        b2_next.cal_error = b1_reg.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready1) v1_reg <= in_valid;
            if (ready2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1) b1_reg <= b1_next;
        if (ready2) b2_reg <= b2_next;
    end

    assign out_valid = v2_reg;
    assign out_beat  = b2_reg;

endmodule

`default_nettype wire

FILE: design/two_point_sensor_calibration_top.sv
// Top level of the two-point sensor calibration block: register file, APB port and pipeline.
// Instantiates tpsc_front, tpsc_div and tpsc_back; uses tpsc_pkg.
//
// Usage:
//   Program the two calibration points of each channel through the APB port
//   (eight registers, byte address 4*index, pready always high) while the
//   pipeline is empty. Then stream sample beats: func picks humidity (0) or
//   temperature (1), raw_sample is the sensor count. Each sample beat yields
//   exactly one reading beat, in order, with the value in tenths of a unit and
//   cal_error set when the channel's two counts are equal (reading is 0 then).
//   Throughput is one beat per clock while the reading side is not stalled.
//   From acceptance to the reading beat's valid a beat passes three front
//   stages (point select, multiply, magnitudes), seven divider stages of four
//   quotient bits each (28-bit dividend), and two back stages (sign, offset
//   and clamp) ending in the output register.
//   Every stage holds a valid bit and loads whenever it is empty or the next
//   stage moves, so bubbles close up. When the receiver stalls, the output
//   register holds its beat; the pipeline behind it keeps filling and only
//   stalls the sample side once all twelve stages are full. Nothing is lost
//   or repeated.
//   Reset clears all valid bits and all calibration registers to zero; no
//   clearing pass is needed.
`default_nettype none

module two_point_sensor_calibration_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tpsc_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [tpsc_pkg::DATA_W-1:0]     pwdata,
    output logic      [tpsc_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready,
    input  wire logic                            sample_valid,
    output logic                                 sample_stall,
    input  wire tpsc_pkg::sample_beat_t          sample,
    output logic                                 reading_valid,
    input  wire logic                            reading_stall,
    output tpsc_pkg::reading_beat_t              reading
);

    tpsc_pkg::cal_cfg_t   cfg_reg;
    tpsc_pkg::reg_index_t reg_idx;
    logic                 wr_en;

    tpsc_pkg::div_stage_t front_data, div_data;
    logic                 front_valid, front_stall;
    logic                 div_valid, div_stall;

    assign pready  = 1'b1;
    assign reg_idx = tpsc_pkg::reg_index_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Write on the access cycle; drop bits above each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                tpsc_pkg::REG_HUM_P0_PCT:  cfg_reg.hum_point0_percent  <= pwdata[6:0];
                tpsc_pkg::REG_HUM_P1_PCT:  cfg_reg.hum_point1_percent  <= pwdata[6:0];
                tpsc_pkg::REG_HUM_P0_CNT:  cfg_reg.hum_point0_count    <= pwdata[15:0];
                tpsc_pkg::REG_HUM_P1_CNT:  cfg_reg.hum_point1_count    <= pwdata[15:0];
                tpsc_pkg::REG_TEMP_P0_DEG: cfg_reg.temp_point0_degrees <= pwdata[6:0];
                tpsc_pkg::REG_TEMP_P1_DEG: cfg_reg.temp_point1_degrees <= pwdata[6:0];
                tpsc_pkg::REG_TEMP_P0_CNT: cfg_reg.temp_point0_count   <= pwdata[15:0];
                tpsc_pkg::REG_TEMP_P1_CNT: cfg_reg.temp_point1_count   <= pwdata[15:0];
                default:                   cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    // Read back as stored, zero-extended
    always_comb
    begin
        unique case (reg_idx)
            tpsc_pkg::REG_HUM_P0_PCT:  prdata = {25'b0, cfg_reg.hum_point0_percent};
            tpsc_pkg::REG_HUM_P1_PCT:  prdata = {25'b0, cfg_reg.hum_point1_percent};
            tpsc_pkg::REG_HUM_P0_CNT:  prdata = {16'b0, cfg_reg.hum_point0_count};
            tpsc_pkg::REG_HUM_P1_CNT:  prdata = {16'b0, cfg_reg.hum_point1_count};
            tpsc_pkg::REG_TEMP_P0_DEG: prdata = {25'b0, cfg_reg.temp_point0_degrees};
            tpsc_pkg::REG_TEMP_P1_DEG: prdata = {25'b0, cfg_reg.temp_point1_degrees};
            tpsc_pkg::REG_TEMP_P0_CNT: prdata = {16'b0, cfg_reg.temp_point0_count};
            tpsc_pkg::REG_TEMP_P1_CNT: prdata = {16'b0, cfg_reg.temp_point1_count};
            default:                   prdata = '0;
        endcase
    end

    tpsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (sample_valid),
        .in_stall  (sample_stall),
        .in_beat   (sample),
        .out_valid (front_valid),
        .out_stall (front_stall),
        .out_data  (front_data)
    );

    tpsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_stall  (front_stall),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_stall (div_stall),
        .out_data  (div_data)
    );

    tpsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_stall  (div_stall),
        .in_data   (div_data),
        .out_valid (reading_valid),
        .out_stall (reading_stall),
        .out_beat  (reading)
    );

endmodule

`default_nettype wire

FILE: verif/tpsc_checker.sv
// Checker for the two-point sensor calibration block: tracks register writes on the APB port,
// predicts one reading beat per accepted sample beat and compares results in order.
// Depends on tpsc_pkg for the beat, configuration and register code types.

module tpsc_checker
    import tpsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                pready,
    input  logic                sample_valid,
    input  logic                sample_stall,
    input  sample_beat_t        sample,
    input  logic                reading_valid,
    input  logic                reading_stall,
    input  reading_beat_t       reading,
    output int                  mismatch_count,
    output int                  readings_due,
    output int                  readings_checked,
    output int                  flagged_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TENTHS_PER_UNIT = 10;

    cal_cfg_t      cal_copy;
    reading_beat_t readings_q[$];

    // Straight line through the two points of the selected channel, then clamp
    function automatic reading_beat_t convert_sample(sample_beat_t s, cal_cfg_t c);
        reading_beat_t res;
        longint        unit0;
        longint        unit1;
        longint        count0;
        longint        count1;
        longint        raw;
        longint        span;
        longint        tenths;
        if (s.func == FUNC_TEMP)
        begin
            unit0  = c.temp_point0_degrees;
            unit1  = c.temp_point1_degrees;
            count0 = $signed(c.temp_point0_count);
            count1 = $signed(c.temp_point1_count);
        end
        else
        begin
            unit0  = c.hum_point0_percent;
            unit1  = c.hum_point1_percent;
            count0 = $signed(c.hum_point0_count);
            count1 = $signed(c.hum_point1_count);
        end
        raw  = $signed(s.raw_sample);
        span = count1 - count0;
        res  = '0;
        if (span == 0)
        begin
            res.cal_error = 1'b1;
            return res;
        end
        tenths = ((raw - count0) * ((unit1 - unit0) * TENTHS_PER_UNIT)) / span
                 + unit0 * TENTHS_PER_UNIT;
        if (s.func == FUNC_TEMP)
        begin
            if (tenths < TEMP_MIN)
                tenths = TEMP_MIN;
            if (tenths > TEMP_MAX)
                tenths = TEMP_MAX;
        end
        else
        begin
            if (tenths < 0)
                tenths = 0;
            if (tenths > HUM_FULL_SCALE)
                tenths = HUM_FULL_SCALE;
        end
        res.reading_tenths = tenths[15:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_beat_t want;
        if (!rst_n)
        begin
            cal_copy = '0;
            readings_q.delete();
            mismatch_count   = 0;
            readings_checked = 0;
            flagged_count    = 0;
            readings_due <= 0;
        end
        else
        begin
            // Mirror register writes, dropping bits above each field
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[ADDR_W-1:2]))
                    REG_HUM_P0_PCT:  cal_copy.hum_point0_percent  = pwdata[6:0];
                    REG_HUM_P1_PCT:  cal_copy.hum_point1_percent  = pwdata[6:0];
                    REG_HUM_P0_CNT:  cal_copy.hum_point0_count    = pwdata[15:0];
                    REG_HUM_P1_CNT:  cal_copy.hum_point1_count    = pwdata[15:0];
                    REG_TEMP_P0_DEG: cal_copy.temp_point0_degrees = pwdata[6:0];
                    REG_TEMP_P1_DEG: cal_copy.temp_point1_degrees = pwdata[6:0];
                    REG_TEMP_P0_CNT: cal_copy.temp_point0_count   = pwdata[15:0];
                    REG_TEMP_P1_CNT: cal_copy.temp_point1_count   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
                readings_q.push_back(convert_sample(sample, cal_copy));
            if (reading_valid && !reading_stall)
            begin
                readings_checked++;
                if (readings_q.size() == 0)
                    report_mismatch($sformatf("reading beat %0d came with nothing expected",
                                              readings_checked));
                else
                begin
                    want = readings_q.pop_front();
                    if (reading.reading_tenths !== want.reading_tenths)
                        report_mismatch($sformatf("beat %0d reading_tenths expected %0d got %0d",
                                                  readings_checked, want.reading_tenths,
                                                  reading.reading_tenths));
                    if (reading.cal_error !== want.cal_error)
                        report_mismatch($sformatf("beat %0d cal_error expected %0b got %0b",
                                                  readings_checked, want.cal_error,
                                                  reading.cal_error));
                    if (want.cal_error)
                        flagged_count++;
                end
            end
            readings_due <= readings_q.size();
        end
    end

endmodule

FILE: verif/two_point_sensor_calibration_top_test.sv
// Testbench top for the two-point sensor calibration block: clock, reset, APB programming,
// sample stimulus, reading-side stall and the final verdict.
// Depends on tpsc_pkg, the block's top level and tpsc_checker.

module two_point_sensor_calibration_top_test;
    import tpsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT       = 37;
    localparam int RANDOM_SETS    = 8;
    localparam int BEATS_PER_SET  = 130;
    localparam int SETTLE_CYCLES  = 20;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                sample_valid  = 1'b0;
    logic                sample_stall;
    sample_beat_t        sample        = '0;
    logic                reading_valid;
    logic                reading_stall = 1'b0;
    reading_beat_t       reading;

    int                  mismatch_count;
    int                  readings_due;
    int                  readings_checked;
    int                  flagged_count;

    // Stimulus-side bookkeeping
    cal_cfg_t            cal_now      = '0;
    bit                  idle_on      = 1'b1;
    logic                stall_enable = 1'b1;
    int                  beats_sent   = 0;
    int                  settings_used = 0;

    two_point_sensor_calibration_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .reading_valid (reading_valid),
        .reading_stall (reading_stall),
        .reading       (reading)
    );

    tpsc_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .sample           (sample),
        .reading_valid    (reading_valid),
        .reading_stall    (reading_stall),
        .reading          (reading),
        .mismatch_count   (mismatch_count),
        .readings_due     (readings_due),
        .readings_checked (readings_checked),
        .flagged_count    (flagged_count)
    );

    always #10 clk = ~clk;

    // Stall the reading side at random while stall_enable is set
    always @(posedge clk)
        reading_stall <= stall_enable && ($urandom_range(99) < IDLE_PCT);

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // One APB write: setup phase, access phase, then an idle phase with psel low so back-to-back
    // writes never raise and drop psel in the same step. Bits above the field are random.
    task automatic write_reg(input reg_index_t idx, input logic [31:0] bits,
                             input logic [31:0] keep);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~keep) | (bits & keep);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write all eight calibration registers
    task automatic program_cal(input cal_cfg_t cfg);
        write_reg(REG_HUM_P0_PCT,  32'(cfg.hum_point0_percent),  32'h7F);
        write_reg(REG_HUM_P1_PCT,  32'(cfg.hum_point1_percent),  32'h7F);
        write_reg(REG_HUM_P0_CNT,  32'(cfg.hum_point0_count),    32'hFFFF);
        write_reg(REG_HUM_P1_CNT,  32'(cfg.hum_point1_count),    32'hFFFF);
        write_reg(REG_TEMP_P0_DEG, 32'(cfg.temp_point0_degrees), 32'h7F);
        write_reg(REG_TEMP_P1_DEG, 32'(cfg.temp_point1_degrees), 32'h7F);
        write_reg(REG_TEMP_P0_CNT, 32'(cfg.temp_point0_count),   32'hFFFF);
        write_reg(REG_TEMP_P1_CNT, 32'(cfg.temp_point1_count),   32'hFFFF);
        cal_now = cfg;
        settings_used++;
    endtask

    // Present one sample beat, optionally after random idle cycles carrying noise,
    // and hold it until the block accepts it
    task automatic send_sample(input func_t f, input logic [15:0] raw);
        sample_beat_t b;
        b.func       = f;
        b.raw_sample = raw;
        while (idle_on && ($urandom_range(99) < IDLE_PCT))
        begin
            sample_valid <= 1'b0;
            sample       <= sample_beat_t'($urandom());
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= b;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // Let an edge pass so the last accepted beat is counted, then wait until every reading is back
    task automatic wait_drained();
        @(posedge clk);
        while (readings_due != 0)
            @(posedge clk);
    endtask

    function automatic logic [6:0] pick_unit();
        case ($urandom_range(9))
            0:       return 7'd0;
            1:       return 7'd127;
            default: return 7'($urandom_range(127));
        endcase
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Second count of a channel: sometimes equal to the first, sometimes within four counts
    // of it so the slope is steep and results hit the clamps
    function automatic logic [15:0] pick_partner(input logic [15:0] first);
        case ($urandom_range(9))
            0:       return first;
            1:       return first + 16'($urandom_range(8)) - 16'd4;
            default: return pick_count();
        endcase
    endfunction

    initial
    begin : stimulus
        cal_cfg_t    cfg;
        func_t       f;
        logic [15:0] raw;
        logic [15:0] anchor;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: both channels have equal counts, so every beat is flagged
        send_sample(FUNC_HUM,  16'h0000);
        send_sample(FUNC_TEMP, 16'h8000);
        send_sample(FUNC_HUM,  16'h7FFF);
        sample_valid <= 1'b0;
        wait_drained();

        // Rising lines; humidity clamps at both ends, temperature spans the full count range
        cfg = '{hum_point0_percent: 7'd20, hum_point1_percent: 7'd80,
                hum_point0_count: -16'sd10000, hum_point1_count: 16'sd10000,
                temp_point0_degrees: 7'd0, temp_point1_degrees: 7'd127,
                temp_point0_count: 16'sh8000, temp_point1_count: 16'sh7FFF};
        program_cal(cfg);
        send_sample(FUNC_HUM,  16'h8000);
        send_sample(FUNC_HUM,  16'h7FFF);
        send_sample(FUNC_HUM,  16'h0000);
        send_sample(FUNC_HUM,  -16'sd10000);
        send_sample(FUNC_HUM,  16'sd10000);
        send_sample(FUNC_TEMP, 16'h8000);
        send_sample(FUNC_TEMP, 16'h7FFF);
        send_sample(FUNC_TEMP, 16'hFFFF);
        send_sample(FUNC_TEMP, 16'h5555);
        sample_valid <= 1'b0;
        wait_drained();

        // Falling lines; the steep temperature slope saturates to both signed limits
        cfg = '{hum_point0_percent: 7'd100, hum_point1_percent: 7'd0,
                hum_point0_count: 16'sd100, hum_point1_count: 16'sd200,
                temp_point0_degrees: 7'd127, temp_point1_degrees: 7'd0,
                temp_point0_count: 16'sd0, temp_point1_count: 16'sd1};
        program_cal(cfg);
        send_sample(FUNC_HUM,  16'h8000);
        send_sample(FUNC_HUM,  16'h7FFF);
        send_sample(FUNC_HUM,  16'sd150);
        send_sample(FUNC_TEMP, 16'h7FFF);
        send_sample(FUNC_TEMP, 16'h8000);
        send_sample(FUNC_TEMP, 16'h0000);
        sample_valid <= 1'b0;
        wait_drained();

        // Flat humidity above full scale; temperature counts equal, so only it is flagged
        cfg = '{hum_point0_percent: 7'd127, hum_point1_percent: 7'd127,
                hum_point0_count: 16'sh8000, hum_point1_count: 16'sh7FFF,
                temp_point0_degrees: 7'd127, temp_point1_degrees: 7'd0,
                temp_point0_count: 16'sh8000, temp_point1_count: 16'sh8000};
        program_cal(cfg);
        send_sample(FUNC_HUM,  16'h0000);
        send_sample(FUNC_TEMP, 16'h0000);
        send_sample(FUNC_TEMP, 16'h8000);
        send_sample(FUNC_HUM,  16'h8000);
        sample_valid <= 1'b0;
        wait_drained();

        // Random part: one calibration setting per burst, extremes first and last
        for (int s = 0; s < RANDOM_SETS; s++)
        begin
            // Two consecutive bursts run with no idling on either side
            idle_on = (s != 2) && (s != 3);
            stall_enable <= idle_on;
            if (s == 0)
                cfg = '{hum_point0_percent: 7'd0, hum_point1_percent: 7'd127,
                        hum_point0_count: 16'sh8000, hum_point1_count: 16'sh7FFF,
                        temp_point0_degrees: 7'd0, temp_point1_degrees: 7'd127,
                        temp_point0_count: 16'sh8000, temp_point1_count: 16'sh7FFF};
            else if (s == RANDOM_SETS - 1)
                cfg = '{hum_point0_percent: 7'd127, hum_point1_percent: 7'd0,
                        hum_point0_count: 16'sh7FFF, hum_point1_count: 16'sh8000,
                        temp_point0_degrees: 7'd127, temp_point1_degrees: 7'd0,
                        temp_point0_count: 16'sh7FFF, temp_point1_count: 16'sh8000};
            else
            begin
                cfg.hum_point0_percent  = pick_unit();
                cfg.hum_point1_percent  = pick_unit();
                cfg.hum_point0_count    = pick_count();
                cfg.hum_point1_count    = pick_partner(cfg.hum_point0_count);
                cfg.temp_point0_degrees = pick_unit();
                cfg.temp_point1_degrees = pick_unit();
                cfg.temp_point0_count   = pick_count();
                cfg.temp_point1_count   = pick_partner(cfg.temp_point0_count);
            end
            program_cal(cfg);

            for (int n = 0; n < BEATS_PER_SET; n++)
            begin
                // Halfway through one burst, hold off until the pipeline has emptied
                if (s == 5 && n == BEATS_PER_SET / 2)
                begin
                    sample_valid <= 1'b0;
                    wait_drained();
                end
                f = func_t'($urandom_range(1));
                if (f == FUNC_TEMP)
                    anchor = $urandom_range(1) ? cal_now.temp_point0_count
                                               : cal_now.temp_point1_count;
                else
                    anchor = $urandom_range(1) ? cal_now.hum_point0_count
                                               : cal_now.hum_point1_count;
                case ($urandom_range(9))
                    0:       raw = 16'h8000;
                    1:       raw = 16'h7FFF;
                    2, 3:    raw = anchor + 16'($urandom_range(16)) - 16'd8;
                    default: raw = 16'($urandom());
                endcase
                send_sample(f, raw);
            end
            sample_valid <= 1'b0;
            wait_drained();
        end

        // Let any stray beat show up before the verdict
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Summary: %0d sample beats over %0d calibration settings, with random idle",
                 beats_sent, settings_used);
        $display("         and stall on both channels; %0d readings checked, %0d flagged",
                 readings_checked, flagged_count);
        if (mismatch_count == 0 && readings_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
design/tpsc_pkg.sv
design/tpsc_front.sv
design/tpsc_div.sv
design/tpsc_back.sv
design/two_point_sensor_calibration_top.sv
verif/tpsc_checker.sv
verif/two_point_sensor_calibration_top_test.sv
